// File: sv/linear_blend_skinning_macros.svh
// Assertion macros shared by the skinning unit modules.
// Each expands to one labeled concurrent assertion clocked on clk; LBS_ASSERT is disabled by rst.
`ifndef LINEAR_BLEND_SKINNING_MACROS_SVH
`define LINEAR_BLEND_SKINNING_MACROS_SVH

// Property checked while the block is out of reset.
`define LBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/lbs_pkg.sv
// Shared types and constants for the linear blend skinning unit.
// Used by lbs_ctrl, lbs_datapath and the top level; depends on nothing.
package lbs_pkg;

  // Operation codes on the input channel.
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_INFLUENCE = 1'b1;

  // Matrix geometry: 4 rows by 3 columns, element index is row*3+column.
  localparam int          ELEMS_PER_BONE = 12;
  localparam logic [3:0]  LAST_ELEM      = 4'd11;
  localparam logic [1:0]  ROW_TRANSLATE  = 2'd3;
  localparam logic [1:0]  ROW_X          = 2'd0;
  localparam logic [1:0]  ROW_Y          = 2'd1;
  localparam logic [1:0]  ROW_Z          = 2'd2;
  localparam logic [1:0]  COL_X          = 2'd0;
  localparam logic [1:0]  COL_Y          = 2'd1;

  // Last value of the drain counter; the drain ends once the accumulators are updated.
  localparam logic [3:0]  DRAIN_LAST     = 4'd3;

  // Datapath widths.
  localparam int TERM_W   = 48;  // one floored product, also the clamp width of t
  localparam int TSUM_W   = 50;  // sum of three products and a translation
  localparam int CONTR_W  = 49;  // floored t * weight
  localparam int ACC_W    = 64;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       write;    // store one matrix element from the input ports
    logic       capture;  // latch an influence from the input ports
    logic       rd_en;    // read one element of the captured bone
    logic [3:0] elem;
    logic [1:0] row;
    logic [1:0] col;
    logic       finish;   // load the output register and clear the accumulators
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;       // output register holds a result that is not taken
  } status_t;

  // Control that travels down the datapath next to each element.
  typedef struct packed {
    logic       vld;
    logic [1:0] row;
    logic [1:0] col;
  } pipe_ctrl_t;

endpackage

// File: sv/lbs_ctrl.sv
// Controller of the skinning unit: sequences element reads and the final output load.
// Depends on lbs_pkg and linear_blend_skinning_macros.svh.
`include "linear_blend_skinning_macros.svh"

module lbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic             last_influence,
  input  lbs_pkg::status_t status,
  output lbs_pkg::cmd_t    cmd
);

  lbs_pkg::state_t state, state_next;
  logic [3:0]      cnt, cnt_next;
  logic            last, last_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbs_pkg::ST_IDLE;
      cnt   <= '0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      last  <= last_next;
    end
  end

  // Next state: twelve reads, a fixed drain, then an optional output load.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    last_next  = last;
    case (state)
      lbs_pkg::ST_IDLE: begin
        if (in_valid && op == lbs_pkg::OP_INFLUENCE) begin
          state_next = lbs_pkg::ST_RUN;
          cnt_next   = '0;
          last_next  = last_influence;
        end
      end
      lbs_pkg::ST_RUN: begin
        if (cnt == lbs_pkg::LAST_ELEM) begin
          state_next = lbs_pkg::ST_DRAIN;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      lbs_pkg::ST_DRAIN: begin
        if (cnt == lbs_pkg::DRAIN_LAST) begin
          state_next = last ? lbs_pkg::ST_FINISH : lbs_pkg::ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      lbs_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          state_next = lbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: the read order walks the rows of one column before the next column.
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.row     = cnt[1:0];
    cmd.col     = cnt[3:2];
    cmd.elem    = 4'({cnt[1:0], 1'b0}) + 4'(cnt[1:0]) + 4'(cnt[3:2]);
    case (state)
      lbs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.write   = in_valid && op == lbs_pkg::OP_WRITE;
        cmd.capture = in_valid && op == lbs_pkg::OP_INFLUENCE;
      end
      lbs_pkg::ST_RUN: begin
        cmd.rd_en = 1'b1;
      end
      lbs_pkg::ST_FINISH: begin
        cmd.finish = !status.out_busy;
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

  `LBS_ASSERT(a_run_to_drain, (state == lbs_pkg::ST_RUN && cnt == lbs_pkg::LAST_ELEM) |=> (state == lbs_pkg::ST_DRAIN), "read sequence did not end after twelve elements")
  `LBS_ASSERT(a_finish_free, cmd.finish |-> !status.out_busy, "output loaded over an untaken result")
  `LBS_ASSERT_ALWAYS(a_port_conflict, !(cmd.write && cmd.rd_en), "table written and read in one cycle")

endmodule

// File: sv/lbs_datapath.sv
// Datapath of the skinning unit: bone matrix table, transform pipeline, accumulators,
// output register. Depends on lbs_pkg and linear_blend_skinning_macros.svh.
`include "linear_blend_skinning_macros.svh"

module lbs_datapath #(
  parameter int MAX_BONES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  lbs_pkg::cmd_t      cmd,
  output lbs_pkg::status_t   status,
  input  logic [7:0]         bone_index,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic [16:0]        weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic               saturated
);

  localparam int DEPTH = MAX_BONES * lbs_pkg::ELEMS_PER_BONE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic signed [lbs_pkg::TERM_W-1:0] T_MAX = {1'b0, {(lbs_pkg::TERM_W-1){1'b1}}};
  localparam logic signed [lbs_pkg::TERM_W-1:0] T_MIN = {1'b1, {(lbs_pkg::TERM_W-1){1'b0}}};
  localparam logic signed [lbs_pkg::ACC_W-1:0]  A_MAX = {1'b0, {(lbs_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [lbs_pkg::ACC_W-1:0]  A_MIN = {1'b1, {(lbs_pkg::ACC_W-1){1'b0}}};
  localparam logic signed [31:0]                P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]                P_MIN = 32'sh8000_0000;

  // Bone table and its read register.
  logic [31:0]   bone_mem [DEPTH];
  logic [31:0]   rdata;
  logic          bone_ok_in;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Captured influence.
  logic [7:0]         bone_q;
  logic               oob_q;
  logic signed [31:0] off_x_q, off_y_q, off_z_q;
  logic [16:0]        w_q;

  // Pipeline.
  lbs_pkg::pipe_ctrl_t                s1, s2;
  logic signed [31:0]                 elem_val;
  logic signed [31:0]                 off_sel;
  logic signed [63:0]                 prod;
  logic signed [lbs_pkg::TERM_W-1:0]  term, term_next;
  logic signed [lbs_pkg::TSUM_W-1:0]  tsum, tsum_next;
  logic signed [lbs_pkg::TERM_W-1:0]  tcl, tcl_next;
  logic                               tcl_clip;
  logic                               t_vld, t_clip;
  logic [1:0]                         t_col;
  logic signed [64:0]                 wprod;
  logic signed [lbs_pkg::CONTR_W-1:0] contrib;
  logic                               c_vld, c_clip;
  logic [1:0]                         c_col;

  // Accumulators.
  logic signed [lbs_pkg::ACC_W-1:0] acc_x, acc_y, acc_z;
  logic signed [lbs_pkg::ACC_W-1:0] acc_sel, acc_new;
  logic signed [lbs_pkg::ACC_W:0]   acc_sum;
  logic                             acc_ovf;
  logic                             sticky;

  // Output clamp.
  logic signed [31:0] px_next, py_next, pz_next;
  logic               clip_x, clip_y, clip_z;

  assign status.out_busy = out_valid && !out_ready;

  // Table addressing; a write outside the table is dropped.
  assign bone_ok_in = 32'(bone_index) < MAX_BONES;
  assign mem_we     = cmd.write && bone_ok_in && 32'(element_index) < lbs_pkg::ELEMS_PER_BONE;
  assign wr_addr    = AW'(32'(bone_index) * lbs_pkg::ELEMS_PER_BONE + 32'(element_index));
  assign rd_addr    = AW'(32'(bone_q) * lbs_pkg::ELEMS_PER_BONE + 32'(cmd.elem));

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bone_mem[wr_addr] <= element_value;
    end
    if (cmd.rd_en) begin
      rdata <= bone_mem[rd_addr];
    end
  end

  // Influence capture; weights above one are taken as one.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bone_q  <= bone_index;
      oob_q   <= !bone_ok_in;
      off_x_q <= offset_x;
      off_y_q <= offset_y;
      off_z_q <= offset_z;
      w_q     <= (weight > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE : weight;
    end
  end

  // Stage two: offset times element, floored to Q32.16; the last row is the translation.
  always_comb begin
    elem_val = oob_q ? 32'sd0 : $signed(rdata);
    case (s1.row)
      lbs_pkg::ROW_X: off_sel = off_x_q;
      lbs_pkg::ROW_Y: off_sel = off_y_q;
      lbs_pkg::ROW_Z: off_sel = off_z_q;
      default:        off_sel = 32'sd0;
    endcase
    prod = off_sel * elem_val;
    if (s1.row == lbs_pkg::ROW_TRANSLATE) begin
      term_next = lbs_pkg::TERM_W'(elem_val);
    end else begin
      term_next = prod[63:16];
    end
  end

  // Stage three: running sum over the rows of one column, clamped to 48 bits at its end.
  always_comb begin
    tsum_next = ((s2.row == lbs_pkg::ROW_X) ? '0 : tsum) + lbs_pkg::TSUM_W'(term);
    tcl_clip  = !((&tsum_next[lbs_pkg::TSUM_W-1:lbs_pkg::TERM_W-1]) ||
                  !(|tsum_next[lbs_pkg::TSUM_W-1:lbs_pkg::TERM_W-1]));
    if (tcl_clip) begin
      tcl_next = tsum_next[lbs_pkg::TSUM_W-1] ? T_MIN : T_MAX;
    end else begin
      tcl_next = tsum_next[lbs_pkg::TERM_W-1:0];
    end
  end

  // Stage four: weight multiply, floored.
  assign wprod = tcl * $signed({1'b0, w_q});

  // Stage five: saturating add into the accumulator of the column.
  always_comb begin
    case (c_col)
      lbs_pkg::COL_X: acc_sel = acc_x;
      lbs_pkg::COL_Y: acc_sel = acc_y;
      default:        acc_sel = acc_z;
    endcase
    acc_sum = (lbs_pkg::ACC_W + 1)'(acc_sel) + (lbs_pkg::ACC_W + 1)'(contrib);
    acc_ovf = acc_sum[lbs_pkg::ACC_W] != acc_sum[lbs_pkg::ACC_W-1];
    if (acc_ovf) begin
      acc_new = acc_sum[lbs_pkg::ACC_W] ? A_MIN : A_MAX;
    end else begin
      acc_new = acc_sum[lbs_pkg::ACC_W-1:0];
    end
  end

  // Pipeline data registers.
  always_ff @(posedge clk) begin
    term <= term_next;
    if (s2.vld) begin
      tsum <= tsum_next;
    end
    if (s2.vld && s2.row == lbs_pkg::ROW_TRANSLATE) begin
      tcl    <= tcl_next;
      t_clip <= tcl_clip;
      t_col  <= s2.col;
    end
    if (t_vld) begin
      contrib <= wprod[64:16];
      c_clip  <= t_clip;
      c_col   <= t_col;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1    <= '0;
      s2    <= '0;
      t_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      s1.vld <= cmd.rd_en;
      s1.row <= cmd.row;
      s1.col <= cmd.col;
      s2     <= s1;
      t_vld  <= s2.vld && s2.row == lbs_pkg::ROW_TRANSLATE;
      c_vld  <= t_vld;
    end
  end

  // Accumulators and the vertex clamp flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      acc_x  <= '0;
      acc_y  <= '0;
      acc_z  <= '0;
      sticky <= 1'b0;
    end else if (c_vld) begin
      case (c_col)
        lbs_pkg::COL_X: acc_x <= acc_new;
        lbs_pkg::COL_Y: acc_y <= acc_new;
        default:        acc_z <= acc_new;
      endcase
      sticky <= sticky || c_clip || acc_ovf;
    end
  end

  // Output clamp to 32 bits.
  always_comb begin
    clip_x  = !((&acc_x[lbs_pkg::ACC_W-1:31]) || !(|acc_x[lbs_pkg::ACC_W-1:31]));
    clip_y  = !((&acc_y[lbs_pkg::ACC_W-1:31]) || !(|acc_y[lbs_pkg::ACC_W-1:31]));
    clip_z  = !((&acc_z[lbs_pkg::ACC_W-1:31]) || !(|acc_z[lbs_pkg::ACC_W-1:31]));
    px_next = clip_x ? (acc_x[lbs_pkg::ACC_W-1] ? P_MIN : P_MAX) : acc_x[31:0];
    py_next = clip_y ? (acc_y[lbs_pkg::ACC_W-1] ? P_MIN : P_MAX) : acc_y[31:0];
    pz_next = clip_z ? (acc_z[lbs_pkg::ACC_W-1] ? P_MIN : P_MAX) : acc_z[31:0];
  end

  // Output register; it holds until the transfer completes.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pos_x     <= px_next;
      pos_y     <= py_next;
      pos_z     <= pz_next;
      saturated <= sticky || clip_x || clip_y || clip_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `LBS_ASSERT(a_finish_drained, cmd.finish |-> (!s1.vld && !s2.vld && !t_vld && !c_vld), "output loaded while the pipeline still holds work")
  `LBS_ASSERT(a_clear_after_finish, cmd.finish |=> (acc_x == 0 && acc_y == 0 && acc_z == 0 && !sticky), "accumulators not cleared after a vertex")
  `LBS_ASSERT(a_t_from_translate, t_vld |-> $past(s2.vld && s2.row == lbs_pkg::ROW_TRANSLATE), "column sum closed before its translation row")

endmodule

// File: sv/linear_blend_skinning.sv
// Linear blend skinning unit. A matrix element write (op 0) is taken while the unit is
// idle and leaves it idle. A bone influence (op 1) holds off the next input until the
// bone's twelve matrix elements have been read one at a time from the bone table and
// the multiply, column sum, weight multiply and accumulate stages have drained. An
// influence marked last then loads the output register, and waits to do so while a
// previous result is still untaken; the next input is taken while a finished result
// waits at the output. The bone table is not cleared at reset; every element an
// influence reads must have been written first.
// Top level; depends on lbs_pkg, lbs_ctrl and lbs_datapath.

module linear_blend_skinning #(
  parameter int MAX_BONES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [7:0]         bone_index,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic [16:0]        weight,
  input  logic               last_influence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic               saturated
);

  lbs_pkg::cmd_t    cmd;
  lbs_pkg::status_t status;

  // Sequencer.
  lbs_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .last_influence (last_influence),
    .status         (status),
    .cmd            (cmd)
  );

  // Table, arithmetic and output register.
  lbs_datapath #(
    .MAX_BONES (MAX_BONES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .bone_index    (bone_index),
    .element_index (element_index),
    .element_value (element_value),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .offset_z      (offset_z),
    .weight        (weight),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .saturated     (saturated)
  );

endmodule
